// ----- hdl/wdda_pkg.sv -----
// Shared widths, codes and controller/datapath interface types for the Dxy accumulator.
`default_nettype none

package wdda_pkg;

  localparam int unsigned CHROM_W   = 16;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned SNP_W     = 32;
  localparam int unsigned OUT_W     = 48;
  localparam int unsigned SUM_W     = CNT_W + 2;
  localparam int unsigned TERM_W    = 2 * SUM_W + 4;
  localparam int unsigned STEP_W    = $clog2(POS_W);
  localparam int unsigned CLAMP_W   = 17;

  localparam int unsigned MAX_POP_DEF   = 1024;
  localparam int unsigned ACC_WIDTH_DEF = 48;

  localparam logic [POS_W-1:0] WS_RESET = POS_W'(10000);

  localparam int unsigned S_TDATA_W = 120;
  localparam int unsigned M_TDATA_W = 320;

  typedef enum logic {
    OP_SITE = 1'b0,
    OP_END  = 1'b1
  } op_e;

  // Divider step codes; HH to CMP also select the shared multiplier operands
  localparam logic [STEP_W-1:0] STEP_HH   = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_HM0  = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_HM1  = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_HM2  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_HM3  = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_MM0  = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_MM1  = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_CMP  = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_DIFF = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(POS_W - 1);

  typedef struct packed {
    logic              capture;
    logic              div_step;
    logic [STEP_W-1:0] step;
    logic              commit_site;
    logic              commit_end;
  } wdda_cmd_t;

  typedef struct packed {
    logic site_emit;
    logic end_emit;
    logic slot_free;
  } wdda_status_t;

endpackage

`default_nettype wire

// ----- hdl/wdda_ctrl.sv -----
// Controller state machine: sequences capture, divide/multiply steps and commit.
`default_nettype none

module wdda_ctrl
  import wdda_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_op_i,
  output logic         s_ready_o,
  input  wdda_status_t status_i,
  output wdda_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SITE = 4'b0100,
    ST_END  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d           = state_q;
    step_d            = step_q;
    s_ready_o         = 1'b0;
    cmd_o             = '0;
    cmd_o.step        = step_q;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          step_d        = '0;
          state_d       = (s_op_i == OP_END) ? ST_END : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) begin
          state_d = ST_SITE;
        end
      end
      ST_SITE: begin
        // hold while a result must go out and the output register is occupied
        if (!status_i.site_emit || status_i.slot_free) begin
          cmd_o.commit_site = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_END: begin
        if (!status_i.end_emit || status_i.slot_free) begin
          cmd_o.commit_end = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wdda_datapath.sv -----
// Datapath: serial divider, shared multiplier, window state, accumulators, output register.
`default_nettype none

module wdda_datapath
  import wdda_pkg::*;
#(
  parameter int unsigned MAX_POP   = MAX_POP_DEF,
  parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [POS_W-1:0]   cfg_wdata_i,
  input  wdda_cmd_t          cmd_i,
  output wdda_status_t       status_o,
  input  logic [CHROM_W-1:0] chromosome_id_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [CNT_W-1:0]   pop1_hom_ref_i,
  input  logic [CNT_W-1:0]   pop1_het_i,
  input  logic [CNT_W-1:0]   pop1_hom_alt_i,
  input  logic [CNT_W-1:0]   pop2_hom_ref_i,
  input  logic [CNT_W-1:0]   pop2_het_i,
  input  logic [CNT_W-1:0]   pop2_hom_alt_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CHROM_W-1:0] out_chromosome_o,
  output logic [POS_W-1:0]   window_start_o,
  output logic [SNP_W-1:0]   snp_total_o,
  output logic [OUT_W-1:0]   comparison_total_o,
  output logic [OUT_W-1:0]   difference_total_o,
  output logic [OUT_W-1:0]   het_het_total_o,
  output logic [OUT_W-1:0]   het_hom_total_o,
  output logic [OUT_W-1:0]   hom_hom_total_o
);

  localparam int unsigned EXT_W = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] c);
    if (CLAMP_W'(c) > CLAMP_W'(MAX_POP)) begin
      return CNT_W'(MAX_POP);
    end
    return c;
  endfunction

  function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic [ACC_WIDTH-1:0] a,
                                                   input logic [TERM_W-1:0]    b);
    logic [ACC_WIDTH:0] s;
    s = {1'b0, a} + (ACC_WIDTH+1)'(b);
    return s[ACC_WIDTH] ? '1 : s[ACC_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input logic [ACC_WIDTH-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    if (e > EXT_W'({OUT_W{1'b1}})) begin
      return '1;
    end
    return e[OUT_W-1:0];
  endfunction

  // configuration
  logic [POS_W-1:0] ws_q;

  // captured item
  logic [CHROM_W-1:0] chrom_q;
  logic [CNT_W-1:0]   a0_q, a1_q, a2_q, b0_q, b1_q, b2_q;
  logic [SUM_W-1:0]   n1_q, n2_q;
  logic               inf_q;

  // divider
  logic [POS_W-1:0] divisor_q, quot_q, rem_q;

  // per-site terms
  logic [TERM_W-1:0] hh_q, hm_q, mm_q, cp_q, diff_q;

  // window state
  logic               started_q;
  logic [CHROM_W-1:0] cur_chrom_q;
  logic [POS_W-1:0]   cur_win_q;
  logic [SNP_W-1:0]   snp_q;
  logic [ACC_WIDTH-1:0] comp_acc_q, diff_acc_q, hh_acc_q, hm_acc_q, mm_acc_q;

  // output register
  logic out_valid_q;

  // capture-side combinational values
  logic [CNT_W-1:0] a0_c, a1_c, a2_c, b0_c, b1_c, b2_c;
  logic [SUM_W-1:0] n1_c, n2_c;
  logic             inf_c;

  assign a0_c = clamp_cnt(pop1_hom_ref_i);
  assign a1_c = clamp_cnt(pop1_het_i);
  assign a2_c = clamp_cnt(pop1_hom_alt_i);
  assign b0_c = clamp_cnt(pop2_hom_ref_i);
  assign b1_c = clamp_cnt(pop2_het_i);
  assign b2_c = clamp_cnt(pop2_hom_alt_i);
  assign n1_c = SUM_W'(a0_c) + SUM_W'(a1_c) + SUM_W'(a2_c);
  assign n2_c = SUM_W'(b0_c) + SUM_W'(b1_c) + SUM_W'(b2_c);
  // drop sites with an uncalled population or a monomorphic pattern
  assign inf_c = (n1_c != '0) && (n2_c != '0) &&
                 !((a1_c == '0) && (b1_c == '0) &&
                   (((a0_c == '0) && (b0_c == '0)) || ((a2_c == '0) && (b2_c == '0))));

  // restoring divide, one quotient bit per step
  logic [POS_W:0]   shifted;
  logic [POS_W:0]   trial;
  logic             ge;

  assign shifted = {rem_q, quot_q[POS_W-1]};
  assign trial   = shifted - {1'b0, divisor_q};
  assign ge      = (shifted >= {1'b0, divisor_q});

  // shared multiplier
  logic [SUM_W-1:0]   mul_a, mul_b;
  logic [2*SUM_W-1:0] prod;

  always_comb begin
    case (cmd_i.step)
      STEP_HH:  begin mul_a = SUM_W'(a1_q); mul_b = SUM_W'(b1_q); end
      STEP_HM0: begin mul_a = SUM_W'(a0_q); mul_b = SUM_W'(b1_q); end
      STEP_HM1: begin mul_a = SUM_W'(a1_q); mul_b = SUM_W'(b0_q); end
      STEP_HM2: begin mul_a = SUM_W'(a1_q); mul_b = SUM_W'(b2_q); end
      STEP_HM3: begin mul_a = SUM_W'(a2_q); mul_b = SUM_W'(b1_q); end
      STEP_MM0: begin mul_a = SUM_W'(a0_q); mul_b = SUM_W'(b2_q); end
      STEP_MM1: begin mul_a = SUM_W'(a2_q); mul_b = SUM_W'(b0_q); end
      STEP_CMP: begin mul_a = n1_q;         mul_b = n2_q;         end
      default:  begin mul_a = '0;           mul_b = '0;           end
    endcase
  end

  assign prod = (2*SUM_W)'(mul_a) * (2*SUM_W)'(mul_b);

  // scaled terms for the accumulators
  logic [TERM_W-1:0] t_hh, t_hm, t_mm, t_cp;
  assign t_hh = hh_q << 1;
  assign t_hm = hm_q << 1;
  assign t_mm = mm_q << 2;
  assign t_cp = cp_q << 2;

  // status
  logic site_emit, end_emit, slot_free, full;
  assign site_emit = started_q && ((chrom_q != cur_chrom_q) || (quot_q != cur_win_q));
  assign full      = (snp_q != '0) && (comp_acc_q != '0);
  assign end_emit  = started_q && full;
  assign slot_free = !out_valid_q || out_ready_i;

  assign status_o.site_emit = site_emit;
  assign status_o.end_emit  = end_emit;
  assign status_o.slot_free = slot_free;

  logic load_out;
  assign load_out = (cmd_i.commit_site && site_emit) || (cmd_i.commit_end && end_emit);

  // only the low word of the window start is reported
  logic [POS_W-1:0] start_full;
  assign start_full = cur_win_q * ws_q;

  // accumulator next values on a site commit
  logic                 clear_win;
  logic [SNP_W-1:0]     snp_base;
  logic [ACC_WIDTH-1:0] comp_base, diff_base, hh_base, hm_base, mm_base;

  assign clear_win = !started_q || site_emit;
  assign snp_base  = clear_win ? '0 : snp_q;
  assign comp_base = clear_win ? '0 : comp_acc_q;
  assign diff_base = clear_win ? '0 : diff_acc_q;
  assign hh_base   = clear_win ? '0 : hh_acc_q;
  assign hm_base   = clear_win ? '0 : hm_acc_q;
  assign mm_base   = clear_win ? '0 : mm_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= WS_RESET;
      started_q   <= 1'b0;
      cur_chrom_q <= '0;
      cur_win_q   <= '0;
      snp_q       <= '0;
      comp_acc_q  <= '0;
      diff_acc_q  <= '0;
      hh_acc_q    <= '0;
      hm_acc_q    <= '0;
      mm_acc_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ws_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.commit_site) begin
        started_q   <= 1'b1;
        cur_chrom_q <= chrom_q;
        cur_win_q   <= quot_q;
        if (inf_q) begin
          snp_q      <= (snp_base == '1) ? snp_base : snp_base + SNP_W'(1);
          comp_acc_q <= sat_acc(comp_base, t_cp);
          diff_acc_q <= sat_acc(diff_base, diff_q);
          hh_acc_q   <= sat_acc(hh_base, t_hh);
          hm_acc_q   <= sat_acc(hm_base, t_hm);
          mm_acc_q   <= sat_acc(mm_base, t_mm);
        end else begin
          snp_q      <= snp_base;
          comp_acc_q <= comp_base;
          diff_acc_q <= diff_base;
          hh_acc_q   <= hh_base;
          hm_acc_q   <= hm_base;
          mm_acc_q   <= mm_base;
        end
      end else if (cmd_i.commit_end) begin
        started_q   <= 1'b0;
        cur_chrom_q <= '0;
        cur_win_q   <= '0;
        snp_q       <= '0;
        comp_acc_q  <= '0;
        diff_acc_q  <= '0;
        hh_acc_q    <= '0;
        hm_acc_q    <= '0;
        mm_acc_q    <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      chrom_q   <= chromosome_id_i;
      a0_q      <= a0_c;
      a1_q      <= a1_c;
      a2_q      <= a2_c;
      b0_q      <= b0_c;
      b1_q      <= b1_c;
      b2_q      <= b2_c;
      n1_q      <= n1_c;
      n2_q      <= n2_c;
      inf_q     <= inf_c;
      quot_q    <= position_i;
      rem_q     <= '0;
      divisor_q <= (ws_q == '0) ? POS_W'(1) : ws_q;
    end else if (cmd_i.div_step) begin
      quot_q <= {quot_q[POS_W-2:0], ge};
      rem_q  <= ge ? trial[POS_W-1:0] : shifted[POS_W-1:0];
    end

    if (cmd_i.div_step) begin
      case (cmd_i.step) inside
        STEP_HH:   hh_q <= TERM_W'(prod);
        STEP_HM0:  hm_q <= TERM_W'(prod);
        STEP_HM1,
        STEP_HM2,
        STEP_HM3:  hm_q <= hm_q + TERM_W'(prod);
        STEP_MM0:  mm_q <= TERM_W'(prod);
        STEP_MM1:  mm_q <= mm_q + TERM_W'(prod);
        STEP_CMP:  cp_q <= TERM_W'(prod);
        STEP_DIFF: diff_q <= t_hh + t_hm + t_mm;
        default:   ;
      endcase
    end

    if (load_out) begin
      out_chromosome_o   <= cur_chrom_q;
      window_start_o     <= start_full;
      snp_total_o        <= full ? snp_q : '0;
      comparison_total_o <= full ? clamp_out(comp_acc_q) : '0;
      difference_total_o <= full ? clamp_out(diff_acc_q) : '0;
      het_het_total_o    <= full ? clamp_out(hh_acc_q) : '0;
      het_hom_total_o    <= full ? clamp_out(hm_acc_q) : '0;
      hom_hom_total_o    <= full ? clamp_out(mm_acc_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hdl/windowed_dxy_difference_accumulator_core.sv -----
// Top level of the windowed Dxy difference accumulator.
//
// Usage: site records and end-of-stream items enter on the slave stream
// (s_axis_*); tuser bit 0 selects a site record (0) or an end item (1).
// Finished window totals leave on the master stream (m_axis_*), at most
// one result per input transaction. window_size is written through
// cfg_we_i / cfg_wdata_i while the block is idle; zero acts as one.
// Sequence: a site record is accepted, runs 32 iterations of the
// bit-serial window-index divider and is then committed; the shared
// multiplier works through its eight products during the divider
// iterations. An end item is accepted and then committed.
// s_axis_tready is high only between items. A window result appears on
// m_axis_tvalid in the cycle after the closing item's commit.
// The output register holds a result while the receiver stalls; the next
// item is still accepted and processed, and waits at its commit only if
// it must emit a result while the previous one has not been taken.
// Reset clears all window state and restores window_size to 10000.
`default_nettype none

module windowed_dxy_difference_accumulator_core
  import wdda_pkg::*;
#(
  parameter int unsigned MAX_POP   = MAX_POP_DEF,
  parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [POS_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [15:0] chromosome_id, [47:16] position, [58:48] pop1_hom_ref,
  // [69:59] pop1_het, [80:70] pop1_hom_alt, [91:81] pop2_hom_ref,
  // [102:92] pop2_het, [113:103] pop2_hom_alt, [119:114] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [0:0]           s_axis_tuser,   // [0] op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] out_chromosome, [47:16] window_start, [79:48] snp_total,
  // [127:80] comparison_total, [175:128] difference_total,
  // [223:176] het_het_total, [271:224] het_hom_total, [319:272] hom_hom_total
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  wdda_cmd_t    cmd;
  wdda_status_t status;

  logic [CHROM_W-1:0] out_chromosome;
  logic [POS_W-1:0]   window_start;
  logic [SNP_W-1:0]   snp_total;
  logic [OUT_W-1:0]   comparison_total, difference_total;
  logic [OUT_W-1:0]   het_het_total, het_hom_total, hom_hom_total;

  wdda_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_op_i    (s_axis_tuser[0]),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  wdda_datapath #(
    .MAX_POP   (MAX_POP),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .chromosome_id_i    (s_axis_tdata[15:0]),
    .position_i         (s_axis_tdata[47:16]),
    .pop1_hom_ref_i     (s_axis_tdata[58:48]),
    .pop1_het_i         (s_axis_tdata[69:59]),
    .pop1_hom_alt_i     (s_axis_tdata[80:70]),
    .pop2_hom_ref_i     (s_axis_tdata[91:81]),
    .pop2_het_i         (s_axis_tdata[102:92]),
    .pop2_hom_alt_i     (s_axis_tdata[113:103]),
    .out_valid_o        (m_axis_tvalid),
    .out_ready_i        (m_axis_tready),
    .out_chromosome_o   (out_chromosome),
    .window_start_o     (window_start),
    .snp_total_o        (snp_total),
    .comparison_total_o (comparison_total),
    .difference_total_o (difference_total),
    .het_het_total_o    (het_het_total),
    .het_hom_total_o    (het_hom_total),
    .hom_hom_total_o    (hom_hom_total)
  );

  assign m_axis_tdata = {hom_hom_total, het_hom_total, het_het_total, difference_total,
                         comparison_total, snp_total, window_start, out_chromosome};

endmodule

`default_nettype wire

// ----- hdl/wdda_checker.sv -----
// Port-level checker for the Dxy accumulator, bound to the top level.
`default_nettype none

module wdda_checker
  import wdda_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [0:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready
);

  logic site_acc;
  assign site_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_SITE);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // one item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item accepted while busy");

  // the input is still closed after a site record's whole divide
  a_site_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    site_acc |-> ##33 !s_axis_tready)
    else $error("site record finished before divider completed");

  // results are only launched from a commit cycle, never while idle
  a_emit_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a committing item");

endmodule

bind windowed_dxy_difference_accumulator_core wdda_checker u_wdda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

// ----- verif/windowed_dxy_difference_accumulator_core_tb.sv -----
// Self-checking testbench for the windowed Dxy difference accumulator core.
`timescale 1ns / 100ps

typedef struct packed {
  logic [5:0]  pad;
  logic [10:0] p2_alt;
  logic [10:0] p2_het;
  logic [10:0] p2_ref;
  logic [10:0] p1_alt;
  logic [10:0] p1_het;
  logic [10:0] p1_ref;
  logic [31:0] position;
  logic [15:0] chrom;
} site_rec_t;

typedef struct packed {
  logic [47:0] hom_hom;
  logic [47:0] het_hom;
  logic [47:0] het_het;
  logic [47:0] difference;
  logic [47:0] comparison;
  logic [31:0] snp;
  logic [31:0] wstart;
  logic [15:0] chrom;
} window_totals_t;

class dxy_window_scoreboard;
  localparam logic [63:0] ACC_CAP = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] SNP_CAP = 64'h0000_0000_FFFF_FFFF;

  logic [31:0]    window_size = 32'd10000;
  bit             started;
  logic [15:0]    cur_chrom;
  logic [31:0]    cur_win;
  logic [63:0]    snp_acc, comp_acc, diff_acc, hh_acc, hm_acc, mm_acc;
  window_totals_t windows_due[$];
  int             errors;

  function int pending();
    return windows_due.size();
  endfunction

  function void clear_totals();
    snp_acc = 0; comp_acc = 0; diff_acc = 0;
    hh_acc = 0; hm_acc = 0; mm_acc = 0;
  endfunction

  function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
    if (a > cap) a = cap;
    if (b > cap - a) return cap;
    return a + b;
  endfunction

  function logic [63:0] clamp_count(logic [10:0] c);
    return (c > 11'd1024) ? 64'd1024 : 64'(c);
  endfunction

  // Close the current window; an empty one still reports its location.
  function void close_window();
    window_totals_t w;
    logic [63:0]    start64;
    bit             full;
    start64 = 64'(cur_win) * 64'(window_size);
    full = (snp_acc > 0) && (comp_acc > 0);
    w.chrom      = cur_chrom;
    w.wstart     = start64[31:0];
    w.snp        = full ? snp_acc[31:0] : '0;
    w.comparison = full ? comp_acc[47:0] : '0;
    w.difference = full ? diff_acc[47:0] : '0;
    w.het_het    = full ? hh_acc[47:0] : '0;
    w.het_hom    = full ? hm_acc[47:0] : '0;
    w.hom_hom    = full ? mm_acc[47:0] : '0;
    windows_due = {windows_due, w};
  endfunction

  function void note_input(wdda_pkg::op_e op, site_rec_t s);
    logic [31:0] ws_eff, win;
    logic [63:0] a0, a1, a2, b0, b1, b2, n1, n2, hh, hm, mm;
    if (op == wdda_pkg::OP_END) begin
      if (started && snp_acc > 0 && comp_acc > 0) close_window();
      started = 0;
      cur_chrom = '0;
      cur_win = '0;
      clear_totals();
      return;
    end
    ws_eff = (window_size == 0) ? 32'd1 : window_size;
    win = s.position / ws_eff;
    if (!started) begin
      started = 1;
      cur_chrom = s.chrom;
      cur_win = win;
      clear_totals();
    end else if (s.chrom != cur_chrom || win != cur_win) begin
      close_window();
      cur_chrom = s.chrom;
      cur_win = win;
      clear_totals();
    end
    a0 = clamp_count(s.p1_ref); a1 = clamp_count(s.p1_het); a2 = clamp_count(s.p1_alt);
    b0 = clamp_count(s.p2_ref); b1 = clamp_count(s.p2_het); b2 = clamp_count(s.p2_alt);
    n1 = a0 + a1 + a2;
    n2 = b0 + b1 + b2;
    // drop uncalled and monomorphic sites
    if (n1 == 0 || n2 == 0) return;
    if (a1 + b1 == 0 && (a0 + b0 == 0 || a2 + b2 == 0)) return;
    hh = 2 * a1 * b1;
    hm = 2 * (a0 * b1 + a1 * b0 + a1 * b2 + a2 * b1);
    mm = 4 * (a0 * b2 + a2 * b0);
    snp_acc  = sat_add(snp_acc, 1, SNP_CAP);
    comp_acc = sat_add(comp_acc, 4 * n1 * n2, ACC_CAP);
    diff_acc = sat_add(diff_acc, hh + hm + mm, ACC_CAP);
    hh_acc   = sat_add(hh_acc, hh, ACC_CAP);
    hm_acc   = sat_add(hm_acc, hm, ACC_CAP);
    mm_acc   = sat_add(mm_acc, mm, ACC_CAP);
  endfunction

  function int check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function void check_result(logic [319:0] data);
    window_totals_t got, want;
    got = data;
    if (windows_due.size() == 0) begin
      $display("%0t: window result expected none actual %h", $time, data);
      errors++;
      return;
    end
    want = windows_due.pop_front();
    errors += check_field("out_chromosome", want.chrom, got.chrom);
    errors += check_field("window_start", want.wstart, got.wstart);
    errors += check_field("snp_total", want.snp, got.snp);
    errors += check_field("comparison_total", want.comparison, got.comparison);
    errors += check_field("difference_total", want.difference, got.difference);
    errors += check_field("het_het_total", want.het_het, got.het_het);
    errors += check_field("het_hom_total", want.het_hom, got.het_hom);
    errors += check_field("hom_hom_total", want.hom_hom, got.hom_hom);
  endfunction
endclass

module windowed_dxy_difference_accumulator_core_tb;
  import wdda_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [POS_W-1:0]     cfg_wdata = '0;
  logic                 s_valid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_data = '0;
  logic [0:0]           s_user = '0;
  logic                 m_axis_tvalid;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  dxy_window_scoreboard sb = new();

  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  windowed_dxy_difference_accumulator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check each transaction, then pick the next tready.
  always @(posedge clk_i) begin
    bit ready_next;
    if (rst_ni && m_axis_tvalid && m_ready) sb.check_result(m_axis_tdata);
    if (long_hold_req) begin
      hold_left = 600;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    m_ready <= ready_next;
  end

  task automatic send_item(input op_e op, input site_rec_t s);
    s_valid <= 1'b1;
    s_data <= s;
    s_user <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(op, s);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic send_site(input logic [15:0] chrom, input logic [31:0] pos,
                           input logic [10:0] a0, a1, a2, b0, b1, b2);
    send_item(OP_SITE, '{pad: '0, p2_alt: b2, p2_het: b1, p2_ref: b0,
                         p1_alt: a2, p1_het: a1, p1_ref: a0, position: pos, chrom: chrom});
  endtask

  // Hold until every window has come out and the core has gone quiet.
  task automatic drain();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_window_size(input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.window_size = value;
  endtask

  function automatic logic [10:0] rand_count();
    int r;
    r = $urandom_range(0, 15);
    if (r < 3) return '0;
    if (r == 3) return 11'd1024;
    if (r == 4) return 11'($urandom_range(1025, 2047));
    if (r < 7) return 11'($urandom_range(0, 2047));
    return 11'($urandom_range(0, 60));
  endfunction

  function automatic site_rec_t rand_counts();
    site_rec_t s;
    int r;
    s = '0;
    s.p1_ref = rand_count(); s.p1_het = rand_count(); s.p1_alt = rand_count();
    s.p2_ref = rand_count(); s.p2_het = rand_count(); s.p2_alt = rand_count();
    r = $urandom_range(0, 19);
    if (r < 2) begin
      // monomorphic: no het and one homozygous class missing in both
      s.p1_het = '0; s.p2_het = '0;
      if (r == 0) begin s.p1_ref = '0; s.p2_ref = '0; end
      else begin s.p1_alt = '0; s.p2_alt = '0; end
    end else if (r == 2) begin
      s.p1_ref = '0; s.p1_het = '0; s.p1_alt = '0;
    end else if (r == 3) begin
      s.p2_ref = '0; s.p2_het = '0; s.p2_alt = '0;
    end
    return s;
  endfunction

  function automatic logic [31:0] next_step(input logic [31:0] w);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, w / 4);
    if (r < 9) return w;
    return $urandom;
  endfunction

  task automatic run_phase(input int n_items);
    int          sent;
    int          run_len;
    logic [15:0] chrom;
    logic [31:0] pos, w;
    site_rec_t   s;
    sent = 0;
    w = (sb.window_size == 0) ? 32'd1 : sb.window_size;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        s = rand_counts();
        s.chrom = 16'($urandom);
        s.position = $urandom;
        send_item(op_e'($urandom_range(0, 1)), s);
        sent++;
      end else begin
        chrom = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        pos = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 100000);
        run_len = $urandom_range(1, 20);
        repeat (run_len) begin
          pos = pos + next_step(w);
          s = rand_counts();
          s.chrom = chrom;
          s.position = pos;
          send_item(OP_SITE, s);
          sent++;
        end
        if ($urandom_range(0, 5) == 0) begin
          send_item(OP_END, '0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [31:0] sizes[7];
    sizes = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd250, 32'd0, 32'd64, 32'd10000};
    sizes[4] = $urandom_range(1, 1 << 20);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, default window size of 10000.
    send_item(OP_END, '0);                                   // end before any site
    send_site(16'd7, 32'd0, 1024, 1024, 1024, 1024, 1024, 1024);
    send_site(16'd7, 32'd9999, 2047, 2047, 2047, 1025, 1500, 2047);
    send_site(16'd7, 32'd5, 0, 0, 0, 3, 4, 5);               // pop1 uncalled
    send_site(16'd7, 32'd6, 3, 4, 5, 0, 0, 0);               // pop2 uncalled
    send_site(16'd7, 32'd7, 9, 0, 0, 4, 0, 0);               // all hom-ref
    send_site(16'd7, 32'd8, 0, 0, 6, 0, 0, 2);               // all hom-alt
    send_site(16'd7, 32'd9, 5, 0, 0, 0, 0, 3);               // hom-hom only
    send_site(16'd7, 32'd10, 0, 1, 0, 0, 1, 0);              // het-het only
    send_site(16'd7, 32'd10000, 0, 0, 0, 0, 0, 0);           // new window, skipped site
    send_site(16'd7, 32'd20000, 2, 0, 0, 2, 0, 0);           // closes an empty window
    send_site(16'hFFFF, 32'hFFFF_FFFF, 1, 2, 3, 4, 5, 6);    // chromosome change
    send_site(16'hFFFF, 32'hFFFF_FFFF, 1024, 0, 0, 0, 0, 1024);
    send_item(OP_END, '0);
    send_item(OP_END, '0);
    send_site(16'd0, 32'd0, 0, 0, 0, 0, 0, 0);
    send_item(OP_END, '0);                                   // started but no SNP
    send_site(16'd3, 32'd123456, 10, 20, 30, 40, 50, 60);
    send_site(16'd3, 32'd123457, 1, 0, 0, 1, 0, 0);
    send_site(16'd4, 32'd123457, 0, 5, 0, 7, 0, 0);
    send_item(OP_END, '0);
    drain();

    foreach (sizes[i]) begin
      write_window_size(sizes[i]);
      if (i == 0) long_hold_req = 1'b1;
      if (i == 6) begin
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
      end
      run_phase(240);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("windowed_dxy_difference_accumulator_core_tb OK");
    end else begin
      $display("windowed_dxy_difference_accumulator_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("windowed_dxy_difference_accumulator_core_tb NOT OK");
    $finish;
  end

endmodule

// ----- windowed_dxy_difference_accumulator_core.f -----
hdl/wdda_pkg.sv
hdl/wdda_ctrl.sv
hdl/wdda_datapath.sv
hdl/windowed_dxy_difference_accumulator_core.sv
hdl/wdda_checker.sv
verif/windowed_dxy_difference_accumulator_core_tb.sv
